// ----- rtl/tac_pkg.sv -----
// Shared types and constants for the thermistor ADC to Celsius converter.
package tac_pkg;

   localparam int ADC_W     = 12;
   localparam int NUM_W     = 32;   // adc * fixed resistor, covers the default parameters
   localparam int REST_W    = 16;   // full scale minus sample
   localparam int MANT_W    = 32;   // log2 mantissa, Q31 in [1,2)
   localparam int LOG_INT_W = 5;
   localparam int LOG_FRAC  = 32;
   localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
   localparam int LNR_W     = LOG_W + 1;
   localparam int WIDE_W    = 64;
   localparam int MAG_W     = 63;
   localparam int COEF_W    = 40;
   localparam int TEMP_W    = 18;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 40;
   localparam int MUL_LAT   = 5;
   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = 2;

   localparam logic [31:0]       LN2_Q32   = 32'd2977044472;
   localparam logic [MAG_W-1:0]  MAG_CLAMP = {1'b1, 62'd0};

   // Reciprocal: T = 10*2^56 / den. T >= 2^QUO_W exactly when den <= 10*2^35.
   localparam int QUO_W = 21;
   localparam logic [WIDE_W-1:0] BIG_DEN = 64'd343597383680;

   // floor((T - 699264 + 5) / 10) = (T + ROUND_OFS) / 10 - DIV_OFS_Q
   localparam int KELVIN_X2560 = 699264;
   localparam int DIV_OFS_Q    = 70000;
   localparam int ROUND_OFS    = DIV_OFS_Q * 10 - KELVIN_X2560 + 5;
   localparam int XS_W         = 22;
   localparam int PR_W         = 44;
   localparam int RECIP_SH     = 25;
   localparam logic [XS_W-1:0] RECIP10 = 22'd3355443;  // floor(2^25 / 10)
   localparam int QQ_W         = PR_W - RECIP_SH;
   localparam int CEL_W        = 20;

   typedef enum logic [CSR_AW-1:0] {
      CSR_ADC_MIN  = 3'd0,
      CSR_ADC_MAX  = 3'd1,
      CSR_COEF_A   = 3'd2,
      CSR_COEF_B   = 3'd3,
      CSR_COEF_C   = 3'd4,
      CSR_COEF_D   = 3'd5,
      CSR_TEMP_MIN = 3'd6,
      CSR_TEMP_MAX = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic v;
      logic ok;
   } tac_ctl_type;

   typedef struct packed {
      logic              ok;
      logic [NUM_W-1:0]  num;
      logic [REST_W-1:0] rest;
   } tac_job_type;

endpackage

// ----- rtl/tac_if.sv -----
// Request and response channel interfaces.
interface tac_req_if;
   import tac_pkg::*;
   logic             valid;
   logic             ready;
   logic [ADC_W-1:0] adc_sample;
   modport source (output valid, output adc_sample, input ready);
   modport sink   (input valid, input adc_sample, output ready);
endinterface

interface tac_rsp_if;
   import tac_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temp_celsius;
   logic                     reading_valid;
   modport source (output valid, output temp_celsius, output reading_valid, input ready);
   modport sink   (input valid, input temp_celsius, input reading_valid, output ready);
endinterface

// ----- rtl/tac_front.sv -----
// Front end: takes a sample beat, screens it and forms the divider terms.
module tac_front #(
   parameter int ADC_FULL_SCALE = 4095,
   parameter int FIXED_OHMS     = 10000
) (
   input  logic                      clock,
   input  logic                      reset,
   tac_req_if.sink                   req_ch,
   input  logic [tac_pkg::ADC_W-1:0] adc_min,
   input  logic [tac_pkg::ADC_W-1:0] adc_max,
   input  logic                      q_ready,
   output logic                      q_push,
   output tac_pkg::tac_job_type      q_job
);
   import tac_pkg::*;

   logic        v_ff, v_in;
   tac_job_type job_ff, job_in;
   logic        take;
   logic [ADC_W-1:0] adc;

   assign req_ch.ready = !v_ff || q_ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign v_in         = take || (v_ff && !q_ready);
   assign adc          = req_ch.adc_sample;

   always_comb begin
      job_in.ok   = (adc >= adc_min) && (adc <= adc_max) &&
                    (REST_W'(adc) < REST_W'(ADC_FULL_SCALE)) && (adc != '0);
      job_in.num  = NUM_W'(adc) * NUM_W'(FIXED_OHMS);
      job_in.rest = REST_W'(ADC_FULL_SCALE) - REST_W'(adc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         job_ff <= job_in;
      end
   end

   assign q_push = v_ff && q_ready;
   assign q_job  = job_ff;

endmodule

// ----- rtl/tac_queue.sv -----
// Short job queue between the front end and the arithmetic pipeline.
module tac_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  tac_pkg::tac_job_type wjob,
   output logic                 wr_ready,
   input  logic                 pop,
   output logic                 rd_valid,
   output tac_pkg::tac_job_type rjob
);
   import tac_pkg::*;

   tac_job_type       mem_ff [0:QDEPTH-1];
   logic [QPTR_W-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]   cnt_ff, cnt_in;

   assign wr_ready = cnt_ff != (QPTR_W+1)'(QDEPTH);
   assign rd_valid = cnt_ff != '0;
   assign rjob     = mem_ff[rp_ff];

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wjob;
      end
   end

endmodule

// ----- rtl/tac_log2.sv -----
// Pipelined log2 in Q32: normalize, then one squaring round per stage.
module tac_log2 (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  tac_pkg::tac_ctl_type      ctl_i,
   input  logic [tac_pkg::NUM_W-1:0] x_i,
   output tac_pkg::tac_ctl_type      ctl_o,
   output logic [tac_pkg::LOG_W-1:0] y_o
);
   import tac_pkg::*;

   tac_ctl_type          ctl_ff [0:LOG_FRAC];
   logic [MANT_W-1:0]    m_ff   [0:LOG_FRAC];
   logic [LOG_INT_W-1:0] n_ff   [0:LOG_FRAC];
   logic [LOG_FRAC-1:0]  fr_ff  [0:LOG_FRAC];
   logic [LOG_INT_W-1:0] n_in;
   logic [MANT_W-1:0]    m_in;

   // leading one and left-justify into Q31
   always_comb begin
      n_in = '0;
      for (int i = 0; i < NUM_W; i++) begin
         if (x_i[i]) begin
            n_in = LOG_INT_W'(i);
         end
      end
      m_in = MANT_W'(x_i << (LOG_INT_W'(NUM_W - 1) - n_in));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff[0] <= '0;
      end else if (en) begin
         ctl_ff[0] <= ctl_i;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_ff[0]  <= m_in;
         n_ff[0]  <= n_in;
         fr_ff[0] <= '0;
      end
   end

   for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_sq
      logic [2*MANT_W-1:0] sq;
      logic                carry_bit;
      logic [MANT_W-1:0]   mk_in;

      assign sq        = (2*MANT_W)'(m_ff[k-1]) * (2*MANT_W)'(m_ff[k-1]);
      assign carry_bit = sq[2*MANT_W-1];
      // square reached 2: fraction bit set, halve
      assign mk_in     = carry_bit ? sq[2*MANT_W-1:MANT_W] : sq[2*MANT_W-2:MANT_W-1];

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (en) begin
            ctl_ff[k] <= ctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            m_ff[k]  <= mk_in;
            n_ff[k]  <= n_ff[k-1];
            fr_ff[k] <= {fr_ff[k-1][LOG_FRAC-2:0], carry_bit};
         end
      end
   end

   assign ctl_o = ctl_ff[LOG_FRAC];
   assign y_o   = {n_ff[LOG_FRAC], fr_ff[LOG_FRAC]};

endmodule

// ----- rtl/tac_mulrnd.sv -----
// Pipelined y = c + round(a*b / 2^32), magnitude clamped to 2^62.
module tac_mulrnd (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              en,
   input  tac_pkg::tac_ctl_type              ctl_i,
   input  logic signed [tac_pkg::LNR_W-1:0]  a_i,
   input  logic signed [tac_pkg::WIDE_W-1:0] b_i,
   input  logic signed [tac_pkg::WIDE_W-1:0] c_i,   // static while beats are in flight
   output tac_pkg::tac_ctl_type              ctl_o,
   output logic signed [tac_pkg::LNR_W-1:0]  a_o,
   output logic signed [tac_pkg::WIDE_W-1:0] y_o
);
   import tac_pkg::*;

   localparam int LO_W  = 32;
   localparam int AH_W  = LNR_W - LO_W;
   localparam int BH_W  = WIDE_W - LO_W;
   localparam int PH_W  = AH_W + BH_W;
   localparam int MID_W = 2 * LO_W + 1;
   localparam int SUM_W = 2 * LO_W + AH_W + 2;

   tac_ctl_type             ctl_ff [0:MUL_LAT-1];
   logic signed [LNR_W-1:0] a_ff   [0:MUL_LAT-1];
   logic                    neg_ff [0:MUL_LAT-2];

   logic [LNR_W-1:0]   am_ff, am_in;
   logic [WIDE_W-1:0]  bm_ff, bm_in;
   logic [2*LO_W-1:0]  pll_ff, plh_ff;
   logic [PH_W-1:0]    phl_ff, phh_ff, phh2_ff;
   logic [MID_W-1:0]   mid_ff;
   logic [LO_W:0]      lo_ff;
   logic [MID_W-1:0]   lo_sum;
   logic [SUM_W-1:0]   r_sum;
   logic [MAG_W-1:0]   r_ff, r_in;
   logic signed [WIDE_W-1:0] rs, y_in;

   assign am_in  = a_i[LNR_W-1] ? $unsigned(-a_i) : $unsigned(a_i);
   assign bm_in  = b_i[WIDE_W-1] ? $unsigned(-b_i) : $unsigned(b_i);
   assign lo_sum = MID_W'(pll_ff) + (MID_W'(1) << (LO_W - 1));
   assign r_sum  = SUM_W'(lo_ff) + SUM_W'(mid_ff) + (SUM_W'(phh2_ff) << LO_W);
   assign r_in   = (r_sum > SUM_W'(MAG_CLAMP)) ? MAG_CLAMP : r_sum[MAG_W-1:0];
   assign rs     = $signed({1'b0, r_ff});
   assign y_in   = c_i + (neg_ff[MUL_LAT-2] ? -rs : rs);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MUL_LAT; i++) begin
            ctl_ff[i] <= '0;
         end
      end else if (en) begin
         ctl_ff[0] <= ctl_i;
         for (int i = 1; i < MUL_LAT; i++) begin
            ctl_ff[i] <= ctl_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff[0]   <= a_i;
         neg_ff[0] <= a_i[LNR_W-1] ^ b_i[WIDE_W-1];
         for (int i = 1; i < MUL_LAT; i++) begin
            a_ff[i] <= a_ff[i-1];
         end
         for (int i = 1; i < MUL_LAT - 1; i++) begin
            neg_ff[i] <= neg_ff[i-1];
         end
         // magnitudes
         am_ff  <= am_in;
         bm_ff  <= bm_in;
         // partial products
         pll_ff <= (2*LO_W)'(am_ff[LO_W-1:0]) * (2*LO_W)'(bm_ff[LO_W-1:0]);
         plh_ff <= (2*LO_W)'(am_ff[LO_W-1:0]) * (2*LO_W)'(bm_ff[WIDE_W-1:LO_W]);
         phl_ff <= PH_W'(am_ff[LNR_W-1:LO_W]) * PH_W'(bm_ff[LO_W-1:0]);
         phh_ff <= PH_W'(am_ff[LNR_W-1:LO_W]) * PH_W'(bm_ff[WIDE_W-1:LO_W]);
         // cross terms, rounded low word; high word kept in step
         mid_ff  <= MID_W'(plh_ff) + MID_W'(phl_ff);
         lo_ff   <= lo_sum[MID_W-1:LO_W];
         phh2_ff <= phh_ff;
         // shifted magnitude, clamped
         r_ff   <= r_in;
         y_o    <= y_in;
      end
   end

   assign ctl_o = ctl_ff[MUL_LAT-1];
   assign a_o   = a_ff[MUL_LAT-1];

endmodule

// ----- rtl/tac_back.sv -----
// Back end: ln R, polynomial, reciprocal, Celsius conversion and output register.
module tac_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   input  tac_pkg::tac_job_type              q_job,
   output logic                              q_pop,
   input  logic signed [tac_pkg::COEF_W-1:0] coef_a,
   input  logic signed [tac_pkg::COEF_W-1:0] coef_b,
   input  logic signed [tac_pkg::COEF_W-1:0] coef_c,
   input  logic signed [tac_pkg::COEF_W-1:0] coef_d,
   input  logic signed [tac_pkg::TEMP_W-1:0] temp_min,
   input  logic signed [tac_pkg::TEMP_W-1:0] temp_max,
   tac_rsp_if.source                         rsp_ch
);
   import tac_pkg::*;

   logic        adv;
   tac_ctl_type ctl0, ctl_la, ctl_lb, ctl_d_ff, ctl_d_in;
   tac_ctl_type ctl_m0, ctl_h1, ctl_h2, ctl_h3;
   logic [LOG_W-1:0] la, lb;
   logic signed [LNR_W-1:0]  lraw_ff, lraw_in, a1, a2;
   logic signed [WIDE_W-1:0] y_ln, y1, y2, den;

   logic out_v_ff;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic                     val_ff, val_in;

   // whole pipeline moves when the output register is free or being drained
   assign adv   = !out_v_ff || rsp_ch.ready;
   assign q_pop = adv && q_valid;
   assign ctl0  = '{v: q_valid, ok: q_job.ok};

   tac_log2 u_log_num (
      .clock (clock), .reset (reset), .en (adv),
      .ctl_i (ctl0), .x_i (q_job.num),
      .ctl_o (ctl_la), .y_o (la)
   );

   tac_log2 u_log_rest (
      .clock (clock), .reset (reset), .en (adv),
      .ctl_i (ctl0), .x_i (NUM_W'(q_job.rest)),
      .ctl_o (ctl_lb), .y_o (lb)
   );

   assign ctl_d_in = '{v: ctl_la.v, ok: ctl_la.ok && ctl_lb.ok};
   assign lraw_in  = $signed({1'b0, la}) - $signed({1'b0, lb});

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_d_ff <= '0;
      end else if (adv) begin
         ctl_d_ff <= ctl_d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lraw_ff <= lraw_in;
      end
   end

   // log2 ratio to ln
   tac_mulrnd u_ln2 (
      .clock (clock), .reset (reset), .en (adv),
      .ctl_i (ctl_d_ff), .a_i (lraw_ff),
      .b_i (WIDE_W'(LN2_Q32)), .c_i ('0),
      .ctl_o (ctl_m0), .a_o (), .y_o (y_ln)
   );

   // Horner: t = D; t = C + L*t; t = B + L*t; t = A + L*t
   tac_mulrnd u_h1 (
      .clock (clock), .reset (reset), .en (adv),
      .ctl_i (ctl_m0), .a_i (y_ln[LNR_W-1:0]),
      .b_i (WIDE_W'(coef_d)), .c_i (WIDE_W'(coef_c)),
      .ctl_o (ctl_h1), .a_o (a1), .y_o (y1)
   );

   tac_mulrnd u_h2 (
      .clock (clock), .reset (reset), .en (adv),
      .ctl_i (ctl_h1), .a_i (a1),
      .b_i (y1), .c_i (WIDE_W'(coef_b)),
      .ctl_o (ctl_h2), .a_o (a2), .y_o (y2)
   );

   tac_mulrnd u_h3 (
      .clock (clock), .reset (reset), .en (adv),
      .ctl_i (ctl_h2), .a_i (a2),
      .b_i (y2), .c_i (WIDE_W'(coef_a)),
      .ctl_o (ctl_h3), .a_o (), .y_o (den)
   );

   // reciprocal, one quotient bit per stage; stage 0 screens the denominator
   tac_ctl_type       dctl_ff [0:QUO_W];
   logic [WIDE_W-1:0] dr_ff   [0:QUO_W];
   logic [WIDE_W-1:0] dd_ff   [0:QUO_W];
   logic [QUO_W-1:0]  dq_ff   [0:QUO_W];
   logic              dbig_ff [0:QUO_W];
   tac_ctl_type       dctl_in;

   assign dctl_in = '{v: ctl_h3.v, ok: ctl_h3.ok && !den[WIDE_W-1] && (den != '0)};

   always_ff @(posedge clock) begin
      if (reset) begin
         dctl_ff[0] <= '0;
      end else if (adv) begin
         dctl_ff[0] <= dctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         dr_ff[0]   <= BIG_DEN;
         dd_ff[0]   <= $unsigned(den);
         dq_ff[0]   <= '0;
         dbig_ff[0] <= $unsigned(den) <= BIG_DEN;
      end
   end

   for (genvar k = 1; k <= QUO_W; k++) begin : g_div
      logic [WIDE_W:0]   sh;
      logic              ge;
      logic [WIDE_W-1:0] rk_in;

      assign sh    = {dr_ff[k-1], 1'b0};
      assign ge    = sh >= {1'b0, dd_ff[k-1]};
      assign rk_in = ge ? WIDE_W'(sh - {1'b0, dd_ff[k-1]}) : sh[WIDE_W-1:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            dctl_ff[k] <= '0;
         end else if (adv) begin
            dctl_ff[k] <= dctl_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            dr_ff[k]   <= rk_in;
            dd_ff[k]   <= dd_ff[k-1];
            dq_ff[k]   <= {dq_ff[k-1][QUO_W-2:0], ge};
            dbig_ff[k] <= dbig_ff[k-1];
         end
      end
   end

   // Kelvin offset and divide by ten; a huge quotient is pinned, it saturates anyway
   tac_ctl_type      f1_ctl_ff, f2_ctl_ff;
   logic [XS_W-1:0]  xs_ff, xs_in, xs2_ff;
   logic [PR_W-1:0]  pr_ff;
   logic [QUO_W-1:0] tcl;
   logic [QQ_W-1:0]  q0, qq;
   logic [XS_W-1:0]  rem;
   logic signed [CEL_W-1:0] cel, tmin_x, tmax_x;

   assign tcl    = dbig_ff[QUO_W] ? '1 : dq_ff[QUO_W];
   assign xs_in  = XS_W'(tcl) + XS_W'(ROUND_OFS);
   assign q0     = pr_ff[PR_W-1:RECIP_SH];
   assign rem    = xs2_ff - XS_W'(q0) * XS_W'(10);
   assign qq     = (rem >= XS_W'(10)) ? q0 + 1'b1 : q0;
   assign cel    = $signed(CEL_W'(qq)) - $signed(CEL_W'(DIV_OFS_Q));
   assign tmin_x = CEL_W'(temp_min);
   assign tmax_x = CEL_W'(temp_max);

   always_comb begin
      temp_in = '0;
      val_in  = 1'b0;
      if (f2_ctl_ff.ok) begin
         if (cel > $signed(CEL_W'({1'b0, {(TEMP_W-1){1'b1}}}))) begin
            temp_in = {1'b0, {(TEMP_W-1){1'b1}}};
         end else if (cel < $signed(CEL_W'($signed({1'b1, {(TEMP_W-1){1'b0}}})))) begin
            temp_in = {1'b1, {(TEMP_W-1){1'b0}}};
         end else begin
            temp_in = TEMP_W'(cel);
         end
         val_in = (cel >= tmin_x) && (cel <= tmax_x);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ctl_ff <= '0;
         f2_ctl_ff <= '0;
         out_v_ff  <= 1'b0;
      end else if (adv) begin
         f1_ctl_ff <= dctl_ff[QUO_W];
         f2_ctl_ff <= f1_ctl_ff;
         out_v_ff  <= f2_ctl_ff.v;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         xs_ff   <= xs_in;
         xs2_ff  <= xs_ff;
         pr_ff   <= PR_W'(xs_ff) * PR_W'(RECIP10);
         temp_ff <= temp_in;
         val_ff  <= val_in;
      end
   end

   assign rsp_ch.valid         = out_v_ff;
   assign rsp_ch.temp_celsius  = temp_ff;
   assign rsp_ch.reading_valid = val_ff;

endmodule

// ----- rtl/thermistor_adc_to_celsius.sv -----
// Top level: register file, front end, job queue and arithmetic back end.
//
// Converts one thermistor divider ADC sample per beat into Celsius*256 with an
// extended Steinhart-Hart cubic in ln R. Fully pipelined: a new sample beat is
// taken every clock while the response side keeps up, and every sample yields
// exactly one response beat, in order. An accepted beat passes through 1 front
// register, 1 queue slot, 33 log2 stages (normalize plus one squaring round per
// fraction bit), 1 subtract, 4 x 5 multiply-round stages (ln2 scaling and
// three Horner steps), 1 denominator check, 21 reciprocal stages (one quotient
// bit each), 2 divide-by-ten stages and the output register. A stalled
// response holds the whole back end; the 4-entry queue lets the front end keep
// taking beats meanwhile. Rejected samples (outside the ADC window, at full
// scale, zero, or a non-positive denominator) come out as 0 with reading_valid
// low. Registers are to be written through the csr_ port only while no beat is
// in flight; the block itself does not enforce this.
module thermistor_adc_to_celsius #(
   parameter int ADC_FULL_SCALE = 4095,
   parameter int FIXED_OHMS     = 10000
) (
   input  logic                       clock,
   input  logic                       reset,
   tac_req_if.sink                    req_ch,
   tac_rsp_if.source                  rsp_ch,
   input  logic                       csr_we,
   input  logic [tac_pkg::CSR_AW-1:0] csr_addr,
   input  logic [tac_pkg::CSR_DW-1:0] csr_wdata
);
   import tac_pkg::*;

   // configuration registers
   logic [ADC_W-1:0]          adc_min_ff, adc_max_ff;
   logic signed [COEF_W-1:0]  coef_a_ff, coef_b_ff, coef_c_ff, coef_d_ff;
   logic signed [TEMP_W-1:0]  temp_min_ff, temp_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         adc_min_ff  <= 12'd1;
         adc_max_ff  <= 12'd4094;
         coef_a_ff   <= 40'sd317826907003;
         coef_b_ff   <= 40'sd65900328922;
         coef_c_ff   <= '0;
         coef_d_ff   <= 40'sd24678075;
         temp_min_ff <= -18'sd10240;
         temp_max_ff <= 18'sd32000;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_addr))
            CSR_ADC_MIN:  adc_min_ff  <= csr_wdata[ADC_W-1:0];
            CSR_ADC_MAX:  adc_max_ff  <= csr_wdata[ADC_W-1:0];
            CSR_COEF_A:   coef_a_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_B:   coef_b_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_C:   coef_c_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_COEF_D:   coef_d_ff   <= $signed(csr_wdata[COEF_W-1:0]);
            CSR_TEMP_MIN: temp_min_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            CSR_TEMP_MAX: temp_max_ff <= $signed(csr_wdata[TEMP_W-1:0]);
            default: begin
            end
         endcase
      end
   end

   // front end -> queue -> back end
   logic        q_push, q_wr_ready, q_pop, q_rd_valid;
   tac_job_type q_wjob, q_rjob;

   tac_front #(
      .ADC_FULL_SCALE (ADC_FULL_SCALE),
      .FIXED_OHMS     (FIXED_OHMS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .adc_min (adc_min_ff),
      .adc_max (adc_max_ff),
      .q_ready (q_wr_ready),
      .q_push  (q_push),
      .q_job   (q_wjob)
   );

   tac_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .wjob     (q_wjob),
      .wr_ready (q_wr_ready),
      .pop      (q_pop),
      .rd_valid (q_rd_valid),
      .rjob     (q_rjob)
   );

   tac_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_rd_valid),
      .q_job    (q_rjob),
      .q_pop    (q_pop),
      .coef_a   (coef_a_ff),
      .coef_b   (coef_b_ff),
      .coef_c   (coef_c_ff),
      .coef_d   (coef_d_ff),
      .temp_min (temp_min_ff),
      .temp_max (temp_max_ff),
      .rsp_ch   (rsp_ch)
   );

endmodule
